// File: rtl/framed_xor_chain_line_codec_defines.svh
// Assertion macros for the codec core RTL.
`ifndef FRAMED_XOR_CHAIN_LINE_CODEC_DEFINES_SVH
`define FRAMED_XOR_CHAIN_LINE_CODEC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FXC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FXC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fxc_pkg.sv
// Types, constants and helpers shared by the framed XOR-chain codec.
package fxc_pkg;

    localparam int unsigned KEY_LENGTH_DEF = 10;
    localparam int unsigned KEY_BYTES      = 10;
    localparam int unsigned KEY_W          = 8 * KEY_BYTES;
    localparam int unsigned CFG_ADDR_W     = 2;
    localparam int unsigned CFG_DATA_W     = 64;

    localparam logic [63:0] KEY_LOW_RST  = 64'h3E19_1347_FF3F_81CC;
    localparam logic [15:0] KEY_HIGH_RST = 16'h6301;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE     = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_KEY_HIGH = 2'd2
    } t_reg_idx;

    typedef enum logic {
        MODE_DECODE = 1'b0,
        MODE_ENCODE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [KEY_W-1:0]  key;
    } t_cfg;

    // Select key byte idx; positions past the key read as zero.
    function automatic logic [7:0] key_byte(logic [KEY_W-1:0] key, logic [3:0] idx);
        logic [7:0] res;
        res = 8'h00;
        case (idx)
            4'd0: res = key[7:0];
            4'd1: res = key[15:8];
            4'd2: res = key[23:16];
            4'd3: res = key[31:24];
            4'd4: res = key[39:32];
            4'd5: res = key[47:40];
            4'd6: res = key[55:48];
            4'd7: res = key[63:56];
            4'd8: res = key[71:64];
            4'd9: res = key[79:72];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/fxc_regs.sv
// Configuration registers: mode and the ten-byte key.
module fxc_regs import fxc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_mode       r_mode;
    logic [63:0] r_key_low;
    logic [15:0] r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_DECODE;
            r_key_low  <= KEY_LOW_RST;
            r_key_high <= KEY_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_MODE:     r_mode     <= t_mode'(i_cfg_wdata[0]);
                REG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                REG_KEY_HIGH: r_key_high <= i_cfg_wdata[15:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    assign o_cfg.mode = r_mode;
    assign o_cfg.key  = {r_key_high, r_key_low};

endmodule

// File: rtl/fxc_in_reg.sv
// Input register stage holding one accepted stream byte.
module fxc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       in_xfer;

    assign o_in_ready = !r_valid || i_take;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byte <= i_in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: rtl/fxc_core.sv
// Record framing, key/chain XOR and the result register.
`include "framed_xor_chain_line_codec_defines.svh"
module fxc_core import fxc_pkg::*; #(
    parameter int unsigned KEY_LENGTH = KEY_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_take,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_length,
    output logic       o_end_of_record
);

    localparam int unsigned KI_W = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam logic [KI_W-1:0] KI_LAST = KI_W'(KEY_LENGTH - 1);

    logic [7:0]      r_bytes_left, n_bytes_left;
    logic [KI_W-1:0] r_key_idx,    n_key_idx;
    logic [7:0]      r_chain,      n_chain;
    logic            r_out_valid;
    logic [7:0]      r_out_byte,   n_out_byte;
    logic            r_is_length,  n_is_length;
    logic            r_end,        n_end;
    logic            adv;
    logic            at_length;
    logic [7:0]      coded;

    assign adv       = i_valid && (!r_out_valid || i_out_ready);
    assign at_length = (r_bytes_left == 8'd0);
    assign coded     = i_byte ^ key_byte(i_cfg.key, 4'(r_key_idx)) ^ r_chain;

    always_comb begin
        if (at_length) begin
            n_bytes_left = i_byte;
            n_key_idx    = '0;
            n_chain      = 8'h00;
            n_out_byte   = i_byte;
            n_is_length  = 1'b1;
            n_end        = (i_byte == 8'd0);
        end else begin
            n_bytes_left = r_bytes_left - 8'd1;
            n_key_idx    = (r_key_idx == KI_LAST) ? '0 : r_key_idx + 1'b1;
            // encode chains on ciphertext out, decode on ciphertext in
            n_chain      = (i_cfg.mode == MODE_ENCODE) ? coded : i_byte;
            n_out_byte   = coded;
            n_is_length  = 1'b0;
            n_end        = (r_bytes_left == 8'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 8'd0;
            r_key_idx    <= '0;
            r_chain      <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_bytes_left <= n_bytes_left;
                r_key_idx    <= n_key_idx;
                r_chain      <= n_chain;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte  <= n_out_byte;
            r_is_length <= n_is_length;
            r_end       <= n_end;
        end
    end

    assign o_take          = adv;
    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_is_length     = r_is_length;
    assign o_end_of_record = r_end;

    `FXC_ASSERT_NOW(a_key_idx_range, 1'b1, r_key_idx <= KI_LAST, "key index past key length")
    `FXC_ASSERT_NOW(a_empty_rec_ends, r_out_valid && r_is_length && r_out_byte == 8'd0,
        r_end, "empty record not flagged as ending")
    `FXC_ASSERT_NEXT(a_len_restarts, adv && at_length,
        r_key_idx == '0 && r_chain == 8'h00, "length byte did not restart key and chain")
    `FXC_ASSERT_NEXT(a_last_payload, adv && r_bytes_left == 8'd1,
        r_bytes_left == 8'd0 && r_end, "last payload byte did not close record")

endmodule

// File: rtl/framed_xor_chain_line_codec.sv
// Top level of the framed XOR-chain line codec.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_ready | i_in_byte
//  output   | o_out_valid/ i_out_ready| o_out_byte, o_is_length, o_end_of_record
//  config   | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//
// One byte per cycle sustained while the output is not stalled; a result passes the
// input register, then XOR logic into the result register.
// The record counter, key position and chain byte update in the same cycle as the
// result register, so consecutive bytes of a record go back to back.
// Synchronous active-low reset clears the framing state and loads the default key.
// A stalled output holds its result; the input register still takes one more byte.
module framed_xor_chain_line_codec import fxc_pkg::*; #(
    parameter int unsigned KEY_LENGTH = KEY_LENGTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_is_length,
    output logic                  o_end_of_record
);

    t_cfg       cfg;
    logic       take;
    logic       in_valid_q;
    logic [7:0] in_byte_q;

    fxc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fxc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_take     (take),
        .o_valid    (in_valid_q),
        .o_byte     (in_byte_q)
    );

    fxc_core #(
        .KEY_LENGTH (KEY_LENGTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (in_valid_q),
        .i_byte          (in_byte_q),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_is_length     (o_is_length),
        .o_end_of_record (o_end_of_record)
    );

endmodule

// File: bench/fxc_checker.sv
// Checker for the framed XOR-chain codec: predicts every result byte and compares it.
`timescale 1ns / 100ps

module fxc_checker import fxc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [7:0]            i_out_byte,
    input  logic                  i_is_length,
    input  logic                  i_end_of_record,
    output int                    o_err_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       is_len;
        logic       last;
    } t_coded_byte;

    t_cfg          cfg;
    logic [7:0]    bytes_due;
    logic [3:0]    key_pos;
    logic [7:0]    chain;
    t_coded_byte   coded_q[$];
    t_coded_byte   want;
    t_coded_byte   got;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    // Advance the framing state by one stream byte and return the byte it turns into.
    function automatic t_coded_byte code_byte(logic [7:0] b);
        t_coded_byte res;
        if (bytes_due == 8'd0) begin
            res.data   = b;
            res.is_len = 1'b1;
            res.last   = (b == 8'd0);
            bytes_due  = b;
            key_pos    = 4'd0;
            chain      = 8'd0;
        end else begin
            res.data   = b ^ cfg.key[8*key_pos +: 8] ^ chain;
            res.is_len = 1'b0;
            // the chain always follows the stored (cipher) side of the stream
            chain      = (cfg.mode == MODE_ENCODE) ? res.data : b;
            bytes_due  = bytes_due - 8'd1;
            key_pos    = (key_pos == 4'(KEY_LENGTH_DEF - 1)) ? 4'd0 : key_pos + 4'd1;
            res.last   = (bytes_due == 8'd0);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.mode  = MODE_DECODE;
            cfg.key   = {KEY_HIGH_RST, KEY_LOW_RST};
            bytes_due = 8'd0;
            key_pos   = 4'd0;
            chain     = 8'd0;
            coded_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MODE:     cfg.mode = t_mode'(i_cfg_wdata[0]);
                    REG_KEY_LOW:  cfg.key[63:0] = i_cfg_wdata;
                    REG_KEY_HIGH: cfg.key[79:64] = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{data: i_out_byte, is_len: i_is_length, last: i_end_of_record};
                if (coded_q.size() == 0) begin
                    if (o_err_count < MAX_REPORTS)
                        $display("%0t: unexpected result byte %02h len %0b last %0b",
                                 $realtime, got.data, got.is_len, got.last);
                    o_err_count++;
                end else begin
                    want = coded_q.pop_front();
                    if (want != got) begin
                        if (o_err_count < MAX_REPORTS)
                            $display("%0t: mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     $realtime, want.data, want.is_len, want.last,
                                     got.data, got.is_len, got.last);
                        o_err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                coded_q.push_back(code_byte(i_in_byte));
        end
        o_pending = coded_q.size();
    end

endmodule

// File: bench/tb_framed_xor_chain_line_codec.sv
// Stimulus and verdict for the framed XOR-chain line codec.
`timescale 1ns / 100ps

module tb_framed_xor_chain_line_codec;
    import fxc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PAUSE     = 4;
    localparam int END_CYCLES     = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 20;
    localparam int PHASE_ITEMS    = 60;

    // pacing styles for both sides
    localparam int PACE_NONE  = 0;
    localparam int PACE_FULL  = 1;
    localparam int PACE_MIXED = 2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_in_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_out_byte;
    logic                  o_is_length;
    logic                  o_end_of_record;

    int         err_count;
    int         pending;
    int         tx_pace;
    int         rx_pace;
    bit         hold_req;
    logic [7:0] tx_bytes_due;

    framed_xor_chain_line_codec u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_is_length     (o_is_length),
        .o_end_of_record (o_end_of_record)
    );

    fxc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_is_length     (o_is_length),
        .i_end_of_record (o_end_of_record),
        .o_err_count     (err_count),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(int pace);
        case (pace)
            PACE_NONE: return 0;
            PACE_FULL: return $urandom_range(0, 16);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Offer one byte after a random gap and hold it until the transfer.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted byte has come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    // Next byte of a well-formed record stream: length bytes where a record ends.
    task automatic send_stream_byte();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (tx_bytes_due == 8'd0) begin
            if (pick < 8)       b = 8'd0;
            else if (pick < 90) b = 8'($urandom_range(1, 20));
            else if (pick < 97) b = 8'($urandom_range(21, 100));
            else                b = 8'd255;
            tx_bytes_due = b;
        end else begin
            if (pick < 5)       b = 8'h00;
            else if (pick < 10) b = 8'hFF;
            else                b = 8'($urandom_range(0, 255));
            tx_bytes_due = tx_bytes_due - 8'd1;
        end
        send_byte(b);
    endtask

    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else begin
                stall = draw_wait(rx_pace);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] long_rec[12];
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_byte    = 8'd0;
        i_out_ready  = 1'b0;
        hold_req     = 1'b0;
        tx_pace      = PACE_FULL;
        rx_pace      = PACE_FULL;
        tx_bytes_due = 8'd0;
        long_rec     = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80,
                         8'hFF, 8'h00, 8'h3C, 8'hC3, 8'h7E, 8'hFF};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty record, then a record long enough to wrap the key, reset key, decode
        send_byte(8'd0);
        send_byte(8'd12);
        foreach (long_rec[i]) send_byte(long_rec[i]);
        wait_idle();

        write_reg(REG_MODE, CFG_DATA_W'(MODE_ENCODE));
        write_reg(REG_SPARE, {$urandom, $urandom});
        send_byte(8'd3);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);

        // switch mode and key halfway through a record
        send_byte(8'd4);
        send_byte(8'h11);
        send_byte(8'h22);
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DECODE));
        write_reg(REG_KEY_LOW, {CFG_DATA_W{1'b1}});
        write_reg(REG_KEY_HIGH, '0);
        send_byte(8'h33);
        send_byte(8'h44);
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            case (phase % 5)
                0: begin
                    write_reg(REG_KEY_LOW, '0);
                    write_reg(REG_KEY_HIGH, '0);
                end
                1: begin
                    write_reg(REG_KEY_LOW, {CFG_DATA_W{1'b1}});
                    write_reg(REG_KEY_HIGH, CFG_DATA_W'(16'hFFFF));
                end
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        write_reg(REG_KEY_LOW, {$urandom, $urandom});
                    if ($urandom_range(0, 3) != 0)
                        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
                    if ($urandom_range(0, 4) == 0)
                        write_reg(REG_SPARE, {$urandom, $urandom});
                end
            endcase

            tx_pace = $urandom_range(PACE_NONE, PACE_MIXED);
            rx_pace = $urandom_range(PACE_NONE, PACE_MIXED);
            // long receiver hold-off while bytes keep coming, to back up the input
            if (phase == 2) begin
                tx_pace  = PACE_NONE;
                hold_req = 1'b1;
            end

            // a phase may stop mid-record, so the next settings land inside one
            repeat (PHASE_ITEMS) send_stream_byte();
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/fxc_pkg.sv
rtl/fxc_regs.sv
rtl/fxc_in_reg.sv
rtl/fxc_core.sv
rtl/framed_xor_chain_line_codec.sv
bench/fxc_checker.sv
bench/tb_framed_xor_chain_line_codec.sv
